@@ rtl/ept_pkg.sv @@
`default_nettype none

package ept_pkg;

    // event codes carried by the opcode field
    typedef enum logic [2:0] {
        OP_EDGE    = 3'd0,
        OP_PRESS_A = 3'd1,
        OP_PRESS_B = 3'd2,
        OP_TICK    = 3'd3,
        OP_CALIB   = 3'd4
    } t_opcode;

    localparam int OPCODE_W = 3;
    localparam int TIME_W   = 32;
    localparam int ZONE_W   = 16;

    // configuration register map
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ZONE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 8'd1;

    localparam logic [ZONE_W-1:0] SLOW_ZONE_RESET = 16'd200;
    localparam logic [TIME_W-1:0] DEBOUNCE_RESET  = 32'd200000;

    typedef struct packed {
        logic [ZONE_W-1:0] slow_zone;
        logic [TIME_W-1:0] debounce;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/ept_core.sv @@
`default_nettype none

module ept_core #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire  ept_pkg::t_cfg           i_cfg,
    input  wire  [ept_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire                           i_level_a,
    input  wire                           i_level_b,
    input  wire  [ept_pkg::TIME_W-1:0]    i_time_us,
    output logic signed [COUNT_WIDTH-1:0] o_window_count,
    output logic signed [COUNT_WIDTH-1:0] o_position,
    output logic [COUNT_WIDTH-2:0]        o_rope_length,
    output logic                          o_slow_cw,
    output logic                          o_slow_ccw,
    output logic                          o_stop_a,
    output logic                          o_stop_b,
    output logic                          o_calibrating,
    output logic                          o_seen_a,
    output logic                          o_seen_b
);
    import ept_pkg::*;

    localparam int CMPW = (COUNT_WIDTH + 2 > ZONE_W + 2) ? COUNT_WIDTH + 2 : ZONE_W + 2;
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    // tracker state
    logic signed [COUNT_WIDTH-1:0] r_window, n_window;
    logic signed [COUNT_WIDTH-1:0] r_position, n_position;
    logic [COUNT_WIDTH-2:0]        r_length, n_length;
    logic                          r_calib, n_calib;
    logic                          r_found_a, n_found_a;
    logic                          r_found_b, n_found_b;
    logic [TIME_W-1:0]             r_last_a, n_last_a;
    logic [TIME_W-1:0]             r_last_b, n_last_b;
    logic                          r_slow_cw, n_slow_cw;
    logic                          r_slow_ccw, n_slow_ccw;
    logic                          r_stop_a, n_stop_a;
    logic                          r_stop_b, n_stop_b;

    logic signed [COUNT_WIDTH-1:0] w_win_step;
    logic signed [COUNT_WIDTH-1:0] w_pos_step;
    logic signed [COUNT_WIDTH-1:0] w_win_upd;
    logic signed [COUNT_WIDTH-1:0] w_win_neg;
    logic [COUNT_WIDTH-2:0]        w_mag;
    logic signed [CMPW-1:0]        w_pos_ext;
    logic signed [CMPW-1:0]        w_len_ext;
    logic signed [CMPW-1:0]        w_zone_ext;
    logic [TIME_W-1:0]             w_dt_a;
    logic [TIME_W-1:0]             w_dt_b;
    logic                          w_up;

    // saturating one-pulse step, +1 when the levels differ
    assign w_up = i_level_a ^ i_level_b;
    assign w_win_step = w_up ? ((r_window == CNT_MAX) ? r_window : r_window + CNT_ONE)
                             : ((r_window == CNT_MIN) ? r_window : r_window - CNT_ONE);
    assign w_pos_step = w_up ? ((r_position == CNT_MAX) ? r_position : r_position + CNT_ONE)
                             : ((r_position == CNT_MIN) ? r_position : r_position - CNT_ONE);

    // magnitude of the window count, clamped to the positive range
    assign w_win_neg = -r_window;
    assign w_mag = (r_window == CNT_MIN) ? {(COUNT_WIDTH-1){1'b1}} :
                   r_window[COUNT_WIDTH-1] ? w_win_neg[COUNT_WIDTH-2:0] :
                                             r_window[COUNT_WIDTH-2:0];

    // widened operands for the slow-zone compares
    assign w_pos_ext  = {{(CMPW-COUNT_WIDTH){w_pos_step[COUNT_WIDTH-1]}}, w_pos_step};
    assign w_len_ext  = {{(CMPW-COUNT_WIDTH+1){1'b0}}, r_length};
    assign w_zone_ext = {{(CMPW-ZONE_W){1'b0}}, i_cfg.slow_zone};

    // wrapping time since the last accepted press
    assign w_dt_a = i_time_us - r_last_a;
    assign w_dt_b = i_time_us - r_last_b;

    // next state for one event
    always_comb begin
        w_win_upd  = r_window;
        n_position = r_position;
        n_length   = r_length;
        n_calib    = r_calib;
        n_found_a  = r_found_a;
        n_found_b  = r_found_b;
        n_last_a   = r_last_a;
        n_last_b   = r_last_b;
        n_slow_cw  = r_slow_cw;
        n_slow_ccw = r_slow_ccw;
        n_stop_a   = r_stop_a;
        n_stop_b   = r_stop_b;
        case (i_opcode)
            OP_EDGE: begin
                w_win_upd  = w_win_step;
                n_position = w_pos_step;
                if (!r_calib) begin
                    n_slow_ccw = (w_pos_ext <= w_zone_ext);
                    n_slow_cw  = ((w_len_ext - w_pos_ext) <= w_zone_ext);
                end
            end
            OP_PRESS_A: begin
                if (w_dt_a >= i_cfg.debounce) begin
                    n_last_a = i_time_us;
                    if (r_calib && !r_found_a) begin
                        n_found_a = 1'b1;
                        if (r_found_b) begin
                            n_length   = w_mag;
                            n_calib    = 1'b0;
                            n_position = '0;
                        end else begin
                            w_win_upd = '0;
                        end
                    end else begin
                        n_stop_a = 1'b1;
                    end
                end
            end
            OP_PRESS_B: begin
                if (w_dt_b >= i_cfg.debounce) begin
                    n_last_b = i_time_us;
                    if (r_calib && !r_found_b) begin
                        n_found_b = 1'b1;
                        if (r_found_a) begin
                            n_length   = w_mag;
                            n_calib    = 1'b0;
                            n_position = '0;
                        end else begin
                            w_win_upd = '0;
                        end
                    end else begin
                        n_stop_b = 1'b1;
                    end
                end
            end
            OP_CALIB: begin
                n_calib   = 1'b1;
                n_found_a = 1'b0;
                n_found_b = 1'b0;
            end
            default: begin
            end
        endcase
        // a tick clears the window after it is reported, not while calibrating
        n_window = ((i_opcode == OP_TICK) && !r_calib) ? '0 : w_win_upd;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_position <= '0;
            r_length   <= '0;
            r_calib    <= 1'b0;
            r_found_a  <= 1'b0;
            r_found_b  <= 1'b0;
            r_last_a   <= '0;
            r_last_b   <= '0;
            r_slow_cw  <= 1'b0;
            r_slow_ccw <= 1'b0;
            r_stop_a   <= 1'b0;
            r_stop_b   <= 1'b0;
        end else if (i_en) begin
            r_window   <= n_window;
            r_position <= n_position;
            r_length   <= n_length;
            r_calib    <= n_calib;
            r_found_a  <= n_found_a;
            r_found_b  <= n_found_b;
            r_last_a   <= n_last_a;
            r_last_b   <= n_last_b;
            r_slow_cw  <= n_slow_cw;
            r_slow_ccw <= n_slow_ccw;
            r_stop_a   <= n_stop_a;
            r_stop_b   <= n_stop_b;
        end
    end

    // result view of this event
    assign o_window_count = w_win_upd;
    assign o_position     = n_position;
    assign o_rope_length  = n_length;
    assign o_slow_cw      = n_slow_cw;
    assign o_slow_ccw     = n_slow_ccw;
    assign o_stop_a       = n_stop_a;
    assign o_stop_b       = n_stop_b;
    assign o_calibrating  = n_calib;
    assign o_seen_a       = n_found_a;
    assign o_seen_b       = n_found_b;

endmodule

`default_nettype wire

@@ rtl/encoder_position_tracker_with_limits.sv @@
`default_nettype none

// Quadrature encoder position tracker with end-of-rope limits. Each request is one
// event (encoder A edge, end switch A or B press, tick, start calibration) and
// returns exactly one result with the window count, position, rope length and flags.
// An event waits in an input register until the result register is free or
// draining; then the tracker state and the result register are updated from it,
// so one event is accepted every cycle while results are taken. The state update
// loop sets that rate. The input register holds one more request while a result
// waits for the downstream ready. Configuration writes are always ready; index 0
// is the slow-zone distance, index 1 the debounce time in microseconds.
module encoder_position_tracker_with_limits #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // event request
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [ept_pkg::OPCODE_W-1:0]     i_opcode,
    input  wire                              i_level_a,
    input  wire                              i_level_b,
    input  wire  [ept_pkg::TIME_W-1:0]       i_time_us,
    // result
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic signed [COUNT_WIDTH-1:0]    o_window_count,
    output logic signed [COUNT_WIDTH-1:0]    o_position,
    output logic [COUNT_WIDTH-2:0]           o_rope_length,
    output logic                             o_slow_cw,
    output logic                             o_slow_ccw,
    output logic                             o_stop_a,
    output logic                             o_stop_b,
    output logic                             o_calibrating,
    output logic                             o_seen_a,
    output logic                             o_seen_b,
    // configuration write
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [ept_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [ept_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ept_pkg::*;

    t_cfg                r_cfg;
    logic                r_in_valid;
    logic [OPCODE_W-1:0] r_opcode;
    logic                r_level_a;
    logic                r_level_b;
    logic [TIME_W-1:0]   r_time_us;
    logic                w_adv;

    logic signed [COUNT_WIDTH-1:0] w_window_count;
    logic signed [COUNT_WIDTH-1:0] w_position;
    logic [COUNT_WIDTH-2:0]        w_rope_length;
    logic                          w_slow_cw;
    logic                          w_slow_ccw;
    logic                          w_stop_a;
    logic                          w_stop_b;
    logic                          w_calibrating;
    logic                          w_seen_a;
    logic                          w_seen_b;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_zone <= SLOW_ZONE_RESET;
            r_cfg.debounce  <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLOW_ZONE: r_cfg.slow_zone <= i_cfg_data[ZONE_W-1:0];
                CFG_DEBOUNCE:  r_cfg.debounce  <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // the held event moves on when the result register is free or draining
    assign w_adv   = r_in_valid && (!o_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_opcode  <= i_opcode;
            r_level_a <= i_level_a;
            r_level_b <= i_level_b;
            r_time_us <= i_time_us;
        end
    end

    ept_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_cfg          (r_cfg),
        .i_opcode       (r_opcode),
        .i_level_a      (r_level_a),
        .i_level_b      (r_level_b),
        .i_time_us      (r_time_us),
        .o_window_count (w_window_count),
        .o_position     (w_position),
        .o_rope_length  (w_rope_length),
        .o_slow_cw      (w_slow_cw),
        .o_slow_ccw     (w_slow_ccw),
        .o_stop_a       (w_stop_a),
        .o_stop_b       (w_stop_b),
        .o_calibrating  (w_calibrating),
        .o_seen_a       (w_seen_a),
        .o_seen_b       (w_seen_b)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_window_count <= w_window_count;
            o_position     <= w_position;
            o_rope_length  <= w_rope_length;
            o_slow_cw      <= w_slow_cw;
            o_slow_ccw     <= w_slow_ccw;
            o_stop_a       <= w_stop_a;
            o_stop_b       <= w_stop_b;
            o_calibrating  <= w_calibrating;
            o_seen_a       <= w_seen_a;
            o_seen_b       <= w_seen_b;
        end
    end

endmodule

`default_nettype wire
